// File: src/shabs_pkg.sv
// Shared types, constants and functions of the SHA-256 byte stream hasher.
`default_nettype none
package shabs_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned FillW  = 6;
	localparam int unsigned CountW = 61;
	localparam int unsigned Rounds = 64;
	localparam int unsigned DigestWords = 8;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned LenPos = 56;

	localparam logic [ByteW-1:0] PadMarker = 8'h80;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic            push;
		byte_src_t       src;
		logic            count_en;
		logic            load;
		logic            sched;
		logic            round;
		logic [5:0]      sched_t;
		logic            fold;
		logic            clear;
		logic [IdxW-1:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic [FillW-1:0] fill;
	} status_t;

	function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [WordW-1:0] init_hash(input logic [IdxW-1:0] i);
		unique case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic logic [WordW-1:0] round_const(input logic [5:0] t);
		unique case (t)
			6'd0:  round_const = 32'h428a2f98;
			6'd1:  round_const = 32'h71374491;
			6'd2:  round_const = 32'hb5c0fbcf;
			6'd3:  round_const = 32'he9b5dba5;
			6'd4:  round_const = 32'h3956c25b;
			6'd5:  round_const = 32'h59f111f1;
			6'd6:  round_const = 32'h923f82a4;
			6'd7:  round_const = 32'hab1c5ed5;
			6'd8:  round_const = 32'hd807aa98;
			6'd9:  round_const = 32'h12835b01;
			6'd10: round_const = 32'h243185be;
			6'd11: round_const = 32'h550c7dc3;
			6'd12: round_const = 32'h72be5d74;
			6'd13: round_const = 32'h80deb1fe;
			6'd14: round_const = 32'h9bdc06a7;
			6'd15: round_const = 32'hc19bf174;
			6'd16: round_const = 32'he49b69c1;
			6'd17: round_const = 32'hefbe4786;
			6'd18: round_const = 32'h0fc19dc6;
			6'd19: round_const = 32'h240ca1cc;
			6'd20: round_const = 32'h2de92c6f;
			6'd21: round_const = 32'h4a7484aa;
			6'd22: round_const = 32'h5cb0a9dc;
			6'd23: round_const = 32'h76f988da;
			6'd24: round_const = 32'h983e5152;
			6'd25: round_const = 32'ha831c66d;
			6'd26: round_const = 32'hb00327c8;
			6'd27: round_const = 32'hbf597fc7;
			6'd28: round_const = 32'hc6e00bf3;
			6'd29: round_const = 32'hd5a79147;
			6'd30: round_const = 32'h06ca6351;
			6'd31: round_const = 32'h14292967;
			6'd32: round_const = 32'h27b70a85;
			6'd33: round_const = 32'h2e1b2138;
			6'd34: round_const = 32'h4d2c6dfc;
			6'd35: round_const = 32'h53380d13;
			6'd36: round_const = 32'h650a7354;
			6'd37: round_const = 32'h766a0abb;
			6'd38: round_const = 32'h81c2c92e;
			6'd39: round_const = 32'h92722c85;
			6'd40: round_const = 32'ha2bfe8a1;
			6'd41: round_const = 32'ha81a664b;
			6'd42: round_const = 32'hc24b8b70;
			6'd43: round_const = 32'hc76c51a3;
			6'd44: round_const = 32'hd192e819;
			6'd45: round_const = 32'hd6990624;
			6'd46: round_const = 32'hf40e3585;
			6'd47: round_const = 32'h106aa070;
			6'd48: round_const = 32'h19a4c116;
			6'd49: round_const = 32'h1e376c08;
			6'd50: round_const = 32'h2748774c;
			6'd51: round_const = 32'h34b0bcb5;
			6'd52: round_const = 32'h391c0cb3;
			6'd53: round_const = 32'h4ed8aa4a;
			6'd54: round_const = 32'h5b9cca4f;
			6'd55: round_const = 32'h682e6ff3;
			6'd56: round_const = 32'h748f82ee;
			6'd57: round_const = 32'h78a5636f;
			6'd58: round_const = 32'h84c87814;
			6'd59: round_const = 32'h8cc70208;
			6'd60: round_const = 32'h90befffa;
			6'd61: round_const = 32'ha4506ceb;
			6'd62: round_const = 32'hbef9a3f7;
			default: round_const = 32'hc67178f2;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: src/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
//
// Channel  Dir  tdata                               tuser     tlast
// s_*      in   [7:0] byte_value                    has_byte  end_of_message
// m_*      out  [31:0] digest_word, [34:32] index   -         last_word
//
// The item that fills a 64-byte block is followed by compression
// (one round per cycle) before s_tready returns.
// An end item pads one byte per cycle, compresses each padded block,
// and then offers eight digest words, one per cycle while m_tready is high.
// s_tready is low from padding until the last digest word has been taken.
// Reset restores the initial hash words and clears the length and fill counters.
`default_nettype none
module sha256_byte_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
	input  wire logic        s_tuser,   // [0] has_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic             m_tlast
);

	shabs_pkg::cmd_t    cmd;
	shabs_pkg::status_t status;
	logic [shabs_pkg::WordW-1:0] digest_word;

	shabs_ctrl u_ctrl (
		.s_valid    (s_tvalid),
		.s_has_byte (s_tuser),
		.s_end      (s_tlast),
		.s_ready    (s_tready),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.clk        (clk),
		.arst_n     (arst_n),
		.status     (status),
		.cmd        (cmd)
	);

	shabs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_byte     (s_tdata),
		.status      (status),
		.digest_word (digest_word)
	);

	assign m_tdata = {5'b00000, cmd.out_idx, digest_word};
	assign m_tlast = (cmd.out_idx == 3'd7);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while digest is offered");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[34:32] == 3'd7))
		else $error("last word without final index");

	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block not ready for a new message after the digest");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid
			&& (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)))
		else $error("digest words out of order");

endmodule
`default_nettype wire

// File: src/shabs_dp.sv
// Datapath of the hasher: byte packing, schedule window, round registers and chaining value.
`default_nettype none
module shabs_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire shabs_pkg::cmd_t                    cmd,
	input  wire logic [shabs_pkg::ByteW-1:0]        in_byte,
	output shabs_pkg::status_t                      status,
	output logic [shabs_pkg::WordW-1:0]             digest_word
);

	localparam int unsigned WinDepth = 16;

	logic [shabs_pkg::WordW-1:0]  chain_q [shabs_pkg::DigestWords];
	logic [shabs_pkg::WordW-1:0]  v_q     [shabs_pkg::DigestWords];
	logic [shabs_pkg::WordW-1:0]  win_q   [WinDepth];
	logic [23:0]                  acc_q;
	logic [shabs_pkg::WordW-1:0]  wk_q;
	logic [shabs_pkg::FillW-1:0]  fill_q;
	logic [shabs_pkg::CountW-1:0] count_q;

	logic [63:0]                  bit_len;
	logic [5:0]                   len_lsb;
	logic [shabs_pkg::ByteW-1:0]  push_byte;
	logic [shabs_pkg::WordW-1:0]  sched_w;
	logic [shabs_pkg::WordW-1:0]  t1;
	logic [shabs_pkg::WordW-1:0]  t2;
	logic [shabs_pkg::WordW-1:0]  ch;
	logic [shabs_pkg::WordW-1:0]  maj;

	assign bit_len = {count_q, 3'b000};
	assign len_lsb = {~fill_q[2:0], 3'b000};

	always_comb begin
		case (cmd.src)
			shabs_pkg::SRC_IN:   push_byte = in_byte;
			shabs_pkg::SRC_MARK: push_byte = shabs_pkg::PadMarker;
			shabs_pkg::SRC_LEN:  push_byte = bit_len[len_lsb +: shabs_pkg::ByteW];
			default:             push_byte = '0;
		endcase
	end

	always_comb begin
		if (cmd.sched_t[5:4] == 2'b00) begin
			sched_w = win_q[0];
		end else begin
			sched_w = win_q[0] + shabs_pkg::small_sigma0(win_q[1]) + win_q[9]
				+ shabs_pkg::small_sigma1(win_q[14]);
		end
	end

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + shabs_pkg::big_sigma1(v_q[4]) + ch + wk_q;
	assign t2  = shabs_pkg::big_sigma0(v_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= {acc_q[15:0], push_byte};
		end
		if (cmd.push && (fill_q[1:0] == 2'b11)) begin
			for (int i = 0; i < WinDepth - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WinDepth-1] <= {acc_q, push_byte};
		end else if (cmd.sched) begin
			for (int i = 0; i < WinDepth - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WinDepth-1] <= sched_w;
		end
		if (cmd.sched) begin
			wk_q <= sched_w + shabs_pkg::round_const(cmd.sched_t);
		end
		if (cmd.load) begin
			for (int k = 0; k < shabs_pkg::DigestWords; k++) begin
				v_q[k] <= chain_q[k];
			end
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < shabs_pkg::DigestWords; k++) begin
				chain_q[k] <= shabs_pkg::init_hash(shabs_pkg::IdxW'(k));
			end
			fill_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			for (int k = 0; k < shabs_pkg::DigestWords; k++) begin
				chain_q[k] <= shabs_pkg::init_hash(shabs_pkg::IdxW'(k));
			end
			fill_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.fold) begin
				for (int k = 0; k < shabs_pkg::DigestWords; k++) begin
					chain_q[k] <= chain_q[k] + v_q[k];
				end
			end
			if (cmd.push) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.count_en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign status.fill = fill_q;
	assign digest_word = chain_q[cmd.out_idx];

endmodule
`default_nettype wire

// File: src/shabs_ctrl.sv
// Controller of the hasher: absorbing, padding, compression sequencing and digest output.
`default_nettype none
module shabs_ctrl (
	input  wire logic                s_valid,
	input  wire logic                s_has_byte,
	input  wire logic                s_end,
	output logic                     s_ready,
	output logic                     m_valid,
	input  wire logic                m_ready,
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire shabs_pkg::status_t  status,
	output shabs_pkg::cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} state_t;

	localparam logic [6:0] LastRound = 7'(shabs_pkg::Rounds);
	localparam logic [6:0] FoldCnt   = 7'(shabs_pkg::Rounds + 1);
	localparam logic [shabs_pkg::FillW-1:0] FillLast = '1;
	localparam logic [shabs_pkg::FillW-1:0] FillLen  = shabs_pkg::FillW'(shabs_pkg::LenPos);
	localparam logic [shabs_pkg::IdxW-1:0]  IdxLast  = '1;

	state_t                    state_q;
	logic [6:0]                cnt_q;
	logic [shabs_pkg::IdxW-1:0] idx_q;
	logic                      pad_q;
	logic                      mark_q;
	logic                      final_q;
	logic                      done_q;
	logic                      in_acc;
	logic                      full;

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = (state_q == ST_OUT);
	assign in_acc  = s_valid && s_ready;
	assign full    = (status.fill == FillLast);

	always_comb begin
		cmd          = '0;
		cmd.src      = shabs_pkg::SRC_IN;
		cmd.sched_t  = cnt_q[5:0];
		cmd.out_idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.push     = in_acc && s_has_byte;
				cmd.count_en = in_acc && s_has_byte;
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (!mark_q) begin
					cmd.src = shabs_pkg::SRC_MARK;
				end else if (final_q && (status.fill >= FillLen)) begin
					cmd.src = shabs_pkg::SRC_LEN;
				end else begin
					cmd.src = shabs_pkg::SRC_ZERO;
				end
			end
			ST_COMP: begin
				cmd.load  = (cnt_q == '0);
				cmd.sched = !cnt_q[6];
				cmd.round = (cnt_q != '0) && (cnt_q <= LastRound);
				cmd.fold  = (cnt_q == FoldCnt);
			end
			ST_OUT: begin
				cmd.clear = m_ready && (idx_q == IdxLast);
			end
			default: begin
				cmd.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			final_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					done_q <= 1'b0;
					if (in_acc) begin
						if (s_has_byte && full) begin
							pad_q   <= s_end;
							state_q <= ST_COMP;
						end else if (s_end) begin
							pad_q   <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!mark_q) begin
						mark_q  <= 1'b1;
						final_q <= (status.fill < FillLen);
					end
					if (full) begin
						done_q  <= mark_q && final_q;
						cnt_q   <= '0;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == FoldCnt) begin
						if (done_q) begin
							idx_q   <= '0;
							state_q <= ST_OUT;
						end else if (pad_q) begin
							final_q <= 1'b1;
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (m_ready) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == IdxLast) begin
							pad_q   <= 1'b0;
							mark_q  <= 1'b0;
							final_q <= 1'b0;
							done_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sim/sha256_byte_stream_hasher_test.sv
// Self-checking bench for the byte-stream SHA-256 hasher: random messages against a digest model.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_test;

	typedef struct {
		logic [shabs_pkg::WordW-1:0] word;
		logic [shabs_pkg::IdxW-1:0]  index;
		logic                        last;
	} digest_word_t;

	class sha256_digest_tracker;
		bit [shabs_pkg::WordW-1:0]  hash_state [shabs_pkg::DigestWords];
		bit [shabs_pkg::ByteW-1:0]  block_buf [64];
		bit [shabs_pkg::WordW-1:0]  w_window [16];
		bit [shabs_pkg::WordW-1:0]  k_tab [shabs_pkg::Rounds];
		int unsigned                fill;
		bit [shabs_pkg::CountW-1:0] byte_count;
		digest_word_t               pending_words [$];
		int unsigned                errors;
		int unsigned                words_checked;
		int unsigned                messages;

		function new();
			k_tab = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
				32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
				32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
				32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
				32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
				32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
				32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
				32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
				32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
				32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
				32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
				32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
				32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
			};
			errors = 0;
			words_checked = 0;
			messages = 0;
			restart();
		endfunction

		function void restart();
			hash_state = '{
				32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
			};
			fill = 0;
			byte_count = '0;
		endfunction

		function bit [shabs_pkg::WordW-1:0] ror(bit [shabs_pkg::WordW-1:0] x, int unsigned n);
			return (x >> n) | (x << (shabs_pkg::WordW - n));
		endfunction

		function void compress();
			bit [shabs_pkg::WordW-1:0] v [shabs_pkg::DigestWords];
			bit [shabs_pkg::WordW-1:0] w, w15, w2, s0, s1, t1, t2, ch, maj, a, e;
			int t;
			for (t = 0; t < 16; t++)
				w_window[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
			v = hash_state;
			for (t = 0; t < shabs_pkg::Rounds; t++) begin
				if (t < 16) begin
					w = w_window[t];
				end else begin
					w15 = w_window[(t - 15) & 15];
					w2 = w_window[(t - 2) & 15];
					s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
					s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
					w = w_window[t & 15] + s0 + w_window[(t - 7) & 15] + s1;
					w_window[t & 15] = w;
				end
				a = v[0];
				e = v[4];
				ch = (e & v[5]) ^ (~e & v[6]);
				t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ch + k_tab[t] + w;
				maj = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + maj;
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (t = 0; t < shabs_pkg::DigestWords; t++)
				hash_state[t] += v[t];
		endfunction

		function void absorb_item(bit [shabs_pkg::ByteW-1:0] value, bit has_byte,
				bit end_of_message);
			bit [63:0] bit_len;
			digest_word_t dw;
			int n, i;
			if (has_byte) begin
				byte_count++;
				block_buf[fill] = value;
				fill++;
				if (fill == 64) begin
					compress();
					fill = 0;
				end
			end
			if (!end_of_message)
				return;
			bit_len = {byte_count, 3'b000};
			n = fill;
			block_buf[n] = shabs_pkg::PadMarker;
			n++;
			if (n > shabs_pkg::LenPos) begin
				for (i = n; i < 64; i++)
					block_buf[i] = '0;
				compress();
				n = 0;
			end
			for (i = n; i < shabs_pkg::LenPos; i++)
				block_buf[i] = '0;
			for (i = 0; i < 8; i++)
				block_buf[63 - i] = bit_len[8*i +: 8];
			compress();
			for (i = 0; i < shabs_pkg::DigestWords; i++) begin
				dw.word = hash_state[i];
				dw.index = i[shabs_pkg::IdxW-1:0];
				dw.last = (i == shabs_pkg::DigestWords - 1);
				pending_words.push_back(dw);
			end
			messages++;
			restart();
		endfunction

		function void check_word(logic [39:0] data, logic last);
			digest_word_t exp_w;
			words_checked++;
			if (pending_words.size() == 0) begin
				$error("Unexpected digest word %h with no digest outstanding", data[31:0]);
				errors++;
				return;
			end
			exp_w = pending_words.pop_front();
			if (data[31:0] !== exp_w.word) begin
				$error("digest_word: expected %h, got %h", exp_w.word, data[31:0]);
				errors++;
			end
			if (data[34:32] !== exp_w.index) begin
				$error("word_index: expected %0d, got %0d", exp_w.index, data[34:32]);
				errors++;
			end
			if (last !== exp_w.last) begin
				$error("last_word: expected %0d, got %0d", exp_w.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_digest_tracker tracker = new();
	bit          calm = 1'b0;
	int unsigned items_sent = 0;

	sha256_byte_stream_hasher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_word(m_tdata, m_tlast);
	end

	initial begin
		int hold;
		bit rdy;
		hold = 0;
		rdy = 1'b1;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					rdy = 1'b0;
					hold = $urandom_range(1, 14);
				end else begin
					rdy = 1'b1;
					hold = $urandom_range(1, 20);
				end
			end
			hold--;
			m_tready <= calm ? 1'b1 : rdy;
		end
	end

	task automatic send_item(input bit [7:0] value, input bit has_byte, input bit end_of_message);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= has_byte;
		s_tlast <= end_of_message;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.absorb_item(value, has_byte, end_of_message);
		items_sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_digests();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_message(input int len);
		bit byte_on_end;
		int i;
		byte_on_end = (len > 0) && $urandom_range(0, 1);
		for (i = 0; i < len - byte_on_end; i++) begin
			if (!calm && $urandom_range(0, 19) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
		end
		if (byte_on_end)
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		else
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b1);
		wait_for_digests();

		// One full block is compressed mid-message and the 56 bytes left over force
		// the padding into an extra block.
		send_message(120);

		calm = 1'b1;
		send_message(1);

		wait_for_digests();
		repeat (200) @(posedge clk);
		if (tracker.pending_words.size() != 0) begin
			$error("%0d digest words never arrived", tracker.pending_words.size());
			tracker.errors++;
		end
		$display("Hashed %0d messages from %0d input items, the empty message and an",
			tracker.messages, items_sent);
		$display("extra padding block included; compared %0d digest words under stalls.",
			tracker.words_checked);
		if (tracker.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4ms;
		$display("Timed out waiting for the hasher.");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
src/shabs_pkg.sv
src/shabs_dp.sv
src/shabs_ctrl.sv
src/sha256_byte_stream_hasher.sv
sim/sha256_byte_stream_hasher_test.sv
